[sv/las_pkg.sv]
// ----------------------------------------------------------------------------
// Local alignment score package
// Shared sizes, score helpers and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package las_pkg;

  // Longest sequence that the cell row handles.
  localparam int MAX_LEN = 32;
  localparam int BASE_W  = 2;
  localparam int SEQ_W   = 64;
  localparam int LEN_W   = 6;
  localparam int SCORE_W = 6;
  // Sweep length is up to twice the longest sequence.
  localparam int STEP_W  = LEN_W + 1;
  // Number of pairwise fold steps over the per-column maxima.
  localparam int FOLD_N  = $clog2(MAX_LEN);
  localparam int FC_W    = $clog2(FOLD_N + 1);

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [BASE_W-1:0]  base_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FOLD,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
  } sts_t;

  // Subtract one, floored at zero.
  function automatic score_t dec_floor(input score_t v);
    dec_floor = (v == '0) ? '0 : v - score_t'(1);
  endfunction

  function automatic score_t max2(input score_t a, input score_t b);
    max2 = (a > b) ? a : b;
  endfunction

  // Lengths above the row size saturate.
  function automatic len_t sat_len(input len_t v);
    sat_len = (v > len_t'(MAX_LEN)) ? len_t'(MAX_LEN) : v;
  endfunction

endpackage

[sv/las_ctrl.sv]
// ----------------------------------------------------------------------------
// Local alignment score controller
// Sequences load, anti-diagonal sweep, maximum fold and result hand-off.
// ----------------------------------------------------------------------------
module las_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  las_pkg::sts_t sts,
  output las_pkg::cmd_t cmd
);

  las_pkg::state_t            state_r, state_nxt;
  logic [las_pkg::FC_W-1:0]   fold_cnt_r, fold_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= las_pkg::ST_IDLE;
      fold_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fold_cnt_r  <= fold_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    fold_cnt_nxt  = fold_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_stall      = 1'b1;

    // A waiting result leaves once the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      las_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = las_pkg::ST_SWEEP;
        end
      end
      las_pkg::ST_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.sweep_last) begin
          fold_cnt_nxt = las_pkg::FC_W'(las_pkg::FOLD_N - 1);
          state_nxt    = las_pkg::ST_FOLD;
        end
      end
      las_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (fold_cnt_r == '0) begin
          state_nxt = las_pkg::ST_DONE;
        end else begin
          fold_cnt_nxt = fold_cnt_r - las_pkg::FC_W'(1);
        end
      end
      las_pkg::ST_DONE: begin
        // Move the score to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = las_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = las_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // An accepted beat always starts a sweep.
  a_load_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == las_pkg::ST_SWEEP))
    else $error("accepted beat did not start a sweep");

  // A result is never overwritten while it still waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.publish && out_valid_r && out_stall))
    else $error("pending result overwritten");

  // The last sweep step is followed by the fold.
  a_sweep_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == las_pkg::ST_SWEEP && sts.sweep_last) |=> (state_r == las_pkg::ST_FOLD))
    else $error("fold did not follow the sweep");

endmodule

[sv/las_datapath.sv]
// ----------------------------------------------------------------------------
// Local alignment score datapath
// A row of score cells, one per column, swept one anti-diagonal per step,
// with per-column running maxima folded pairwise at the end.
// ----------------------------------------------------------------------------
module las_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  las_pkg::cmd_t              cmd,
  output las_pkg::sts_t              sts,
  input  logic [las_pkg::SEQ_W-1:0]  seq_a,
  input  logic [las_pkg::LEN_W-1:0]  len_a,
  input  logic [las_pkg::SEQ_W-1:0]  seq_b,
  input  logic [las_pkg::LEN_W-1:0]  len_b,
  output logic [las_pkg::SCORE_W-1:0] best_score
);

  localparam int ROW_W = las_pkg::BASE_W * las_pkg::MAX_LEN;

  las_pkg::len_t             la_sat, lb_sat;
  logic [ROW_W-1:0]          a_sh_r;
  logic [ROW_W-1:0]          b_r;
  las_pkg::len_t             a_left_r;
  las_pkg::len_t             lb_r;
  logic [las_pkg::STEP_W-1:0] cnt_r;
  las_pkg::score_t           best_r;

  las_pkg::base_t  tok_base_r [las_pkg::MAX_LEN];
  logic            tok_v_r    [las_pkg::MAX_LEN];
  las_pkg::score_t h_r        [las_pkg::MAX_LEN];
  las_pkg::score_t dg_r       [las_pkg::MAX_LEN];
  las_pkg::score_t m_r        [las_pkg::MAX_LEN];

  assign la_sat = las_pkg::sat_len(len_a);
  assign lb_sat = las_pkg::sat_len(len_b);

  // Sequence registers and the sweep step counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_sh_r   <= seq_a[ROW_W-1:0];
      b_r      <= seq_b[ROW_W-1:0];
      a_left_r <= la_sat;
      lb_r     <= lb_sat;
      cnt_r    <= las_pkg::STEP_W'(la_sat) + las_pkg::STEP_W'(lb_sat);
    end else if (cmd.step) begin
      a_sh_r <= a_sh_r >> las_pkg::BASE_W;
      if (a_left_r != '0) begin
        a_left_r <= a_left_r - las_pkg::len_t'(1);
      end
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - las_pkg::STEP_W'(1);
      end
    end
  end

  assign sts.sweep_last = (cnt_r <= las_pkg::STEP_W'(1));

  // Score cells: column j works on row (step - j) of the table.
  for (genvar j = 0; j < las_pkg::MAX_LEN; j++) begin : g_cell
    las_pkg::base_t  tin_base;
    logic            tin_v;
    las_pkg::score_t left;
    las_pkg::score_t hit;
    las_pkg::score_t h_new;
    las_pkg::score_t fold_lo;
    las_pkg::score_t fold_hi;
    logic            col_in;

    if (j == 0) begin : g_first
      assign tin_base = a_sh_r[las_pkg::BASE_W-1:0];
      assign tin_v    = (a_left_r != '0);
      assign left     = '0;
    end else begin : g_rest
      assign tin_base = tok_base_r[j-1];
      assign tin_v    = tok_v_r[j-1];
      assign left     = h_r[j-1];
    end

    // Fold pairs (2j, 2j+1) into slot j; slots past the pairs clear.
    if (2 * j + 1 < las_pkg::MAX_LEN) begin : g_pair
      assign fold_lo = m_r[2*j];
      assign fold_hi = m_r[2*j+1];
    end else if (2 * j < las_pkg::MAX_LEN) begin : g_single
      assign fold_lo = m_r[2*j];
      assign fold_hi = '0;
    end else begin : g_none
      assign fold_lo = '0;
      assign fold_hi = '0;
    end

    assign col_in = (las_pkg::len_t'(j) < lb_r);
    assign hit = (tin_base == b_r[las_pkg::BASE_W*j +: las_pkg::BASE_W])
                 ? dg_r[j] + las_pkg::score_t'(1)
                 : las_pkg::dec_floor(dg_r[j]);
    assign h_new = las_pkg::max2(hit,
                     las_pkg::max2(las_pkg::dec_floor(h_r[j]),
                                   las_pkg::dec_floor(left)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tok_v_r[j] <= 1'b0;
      end else if (cmd.load) begin
        tok_v_r[j] <= 1'b0;
      end else if (cmd.step) begin
        tok_v_r[j] <= tin_v;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        h_r[j]  <= '0;
        dg_r[j] <= '0;
        m_r[j]  <= '0;
      end else if (cmd.step) begin
        tok_base_r[j] <= tin_base;
        dg_r[j]       <= left;
        if (tin_v) begin
          h_r[j] <= h_new;
          if (col_in) begin
            m_r[j] <= las_pkg::max2(m_r[j], h_new);
          end
        end
      end else if (cmd.fold) begin
        m_r[j] <= las_pkg::max2(fold_lo, fold_hi);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      best_r <= m_r[0];
    end
  end

  assign best_score = best_r;

  // A published score never exceeds the row length.
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> (best_r <= las_pkg::score_t'(las_pkg::MAX_LEN)))
    else $error("score out of range");

  // Loading clears the running maxima.
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (m_r[0] == '0 && h_r[0] == '0))
    else $error("load did not clear the cells");

  // No base enters the row once the sequence is used up.
  a_no_extra_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && a_left_r == '0) |=> !tok_v_r[0])
    else $error("row token past the sequence end");

endmodule

[sv/local_alignment_score_top.sv]
// ----------------------------------------------------------------------------
// Local alignment score top level
// Smith-Waterman local alignment score of two DNA sequences, linear gaps.
// ----------------------------------------------------------------------------
// One pair is worked at a time. After a beat is accepted, a row of 32 score
// cells sweeps len_a + len_b anti-diagonals of the score table, one per cycle
// (lengths saturated at 32), then folds the per-column maxima pairwise and
// moves the score to the output register. The sweep length is set by the
// anti-diagonal recurrence through the cell row. The next pair is accepted
// while a finished score still waits to be taken.
module local_alignment_score_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [las_pkg::SEQ_W-1:0]   in_seq_a,
  input  logic [las_pkg::LEN_W-1:0]   in_len_a,
  input  logic [las_pkg::SEQ_W-1:0]   in_seq_b,
  input  logic [las_pkg::LEN_W-1:0]   in_len_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [las_pkg::SCORE_W-1:0] out_best_score
);

  las_pkg::cmd_t cmd;
  las_pkg::sts_t sts;

  // Sequencer.
  las_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cell row and score fold.
  las_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .seq_a      (in_seq_a),
    .len_a      (in_len_a),
    .seq_b      (in_seq_b),
    .len_b      (in_len_b),
    .best_score (out_best_score)
  );

endmodule
